// ----- src/pdots_pkg.sv -----
// pdots_pkg: shared types and constants of the transmit pdo trigger scheduler
// used by the channel interfaces and the top level
package pdots_pkg;

   localparam int PDO_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_SYNC  = 2'd1,
      OP_FRAME = 2'd2,
      OP_APP   = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BLOCK_ENABLE    = 3'd0,
      REG_TRANS_TYPES     = 3'd1,
      REG_EVENT_TIMERS    = 3'd2,
      REG_INHIBIT_TIMES   = 3'd3,
      REG_PDO_FLAGS       = 3'd4,
      REG_COB_IDS         = 3'd5,
      REG_PAYLOAD_LENGTHS = 3'd6
   } csr_reg_type;

   // transmission type codes
   localparam logic [7:0] TT_ACYCLIC   = 8'd0;
   localparam logic [7:0] TT_SYNC_MAX  = 8'd240;
   localparam logic [7:0] TT_RTR_SYNC  = 8'd252;
   localparam logic [7:0] TT_RTR_EVENT = 8'd253;
   localparam logic [7:0] TT_EVENT1    = 8'd254;

   localparam logic [10:0] COB_MASK    = 11'h7FF;
   localparam int unsigned MS_TO_US    = 1000;
   localparam int unsigned INH_UNIT_US = 100;
   localparam logic [3:0]  DLC_MAX     = 4'd8;

endpackage

// ----- src/pdots_if.sv -----
// pdots_if: request and response channel interfaces of the scheduler
// depends on pdots_pkg for widths
interface pdots_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] event_time_us;
   logic [7:0]  sync_count;
   logic [2:0]  tpdo_select;
   logic        is_rtr;

   modport source (output valid, output opcode, output event_time_us, output sync_count,
                   output tpdo_select, output is_rtr, input ready);
   modport sink (input valid, input opcode, input event_time_us, input sync_count,
                 input tpdo_select, input is_rtr, output ready);
endinterface

interface pdots_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pdots_pkg::PDO_W-1:0] tpdo_number;
   logic [10:0]                 cob_id;
   logic [3:0]                  dlc;
   logic                        last;

   modport source (output valid, output tpdo_number, output cob_id, output dlc,
                   output last, input ready);
   modport sink (input valid, input tpdo_number, input cob_id, input dlc,
                 input last, output ready);
endinterface

// ----- src/pdo_transmit_trigger_scheduler_top.sv -----
// pdo_transmit_trigger_scheduler_top: transmit pdo trigger scheduler
// depends on pdots_pkg and the channel interfaces in pdots_if
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    opcode, event_time_us, sync_count, tpdo_select, is_rtr
//   rsp_chan  out        valid / ready    tpdo_number, cob_id, dlc, last
//   csr_*     in         csr_we           csr_index, csr_wdata
//
// one request walks the pdos in order through a shared 33-bit subtractor:
// per pdo a load step (time difference), then a compare step, a modulo step
// (sync count) or neither, then a decide step; after the last pdo an emit
// step sends the results, lowest pdo first. req ready only when idle.
// synchronous active-high reset clears control, pdo state and configuration registers.
// a stalled response holds the walk in its emit phase, not the walk itself.
module pdo_transmit_trigger_scheduler_top #(
   parameter int NUM_TPDOS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   pdots_req_if.sink                          req_chan,
   pdots_rsp_if.source                        rsp_chan,
   input  logic                               csr_we,
   input  logic [pdots_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pdots_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = (NUM_TPDOS > 1) ? $clog2(NUM_TPDOS) : 1;
   localparam logic [pdots_pkg::PDO_W-1:0] LAST_PDO = pdots_pkg::PDO_W'(NUM_TPDOS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_CMP,
      S_MOD,
      S_DECIDE,
      S_EMIT
   } state_type;

   // configuration registers
   logic        enable_ff;
   logic [31:0] trans_types_ff;
   logic [63:0] event_timers_ff;
   logic [63:0] inhibit_times_ff;
   logic [11:0] pdo_flags_ff;
   logic [43:0] cob_ids_ff;
   logic [15:0] payload_lengths_ff;

   // per pdo state
   logic        sync_pending_ff [NUM_TPDOS];
   logic [31:0] last_send_ff    [NUM_TPDOS];

   // sequencer
   state_type                    state_ff, state_in;
   pdots_pkg::opcode_type        op_ff, op_in;
   logic [31:0]                  ts_ff, ts_in;
   logic [7:0]                   cnt_ff, cnt_in;
   logic [2:0]                   sel_ff, sel_in;
   logic                         rtr_ff, rtr_in;
   logic [pdots_pkg::PDO_W-1:0]  pdo_ff, pdo_in;
   logic [NUM_TPDOS-1:0]         mask_ff, mask_in;
   logic [31:0]                  diff_ff, diff_in;
   logic [25:0]                  thr_ff, thr_in;
   logic                         ge_ff, ge_in;
   logic [7:0]                   rem_ff, rem_in;
   logic [2:0]                   bit_ff, bit_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pdots_pkg::PDO_W-1:0]  rsp_num_ff, rsp_num_in;
   logic [10:0]                  rsp_cob_ff, rsp_cob_in;
   logic [3:0]                   rsp_dlc_ff, rsp_dlc_in;
   logic                         rsp_last_ff, rsp_last_in;

   // shared subtractor
   logic [31:0] alu_a, alu_b;
   logic [32:0] alu_res;
   logic        alu_borrow;
   logic [8:0]  rem_shift;

   logic [IDX_W-1:0] pidx;
   logic [7:0]       cur_type;
   logic [15:0]      cur_timer, cur_inhibit;
   logic             cur_valid, cur_timer_sup, cur_inh_sup, cur_pend;
   logic             want_send, want_pend, send_now, sel_hit;

   logic [IDX_W-1:0]             emit_idx;
   logic [pdots_pkg::PDO_W-1:0]  emit_pdo;
   logic [NUM_TPDOS-1:0]         mask_clr;
   logic [3:0]                   emit_len;

   logic req_fire;

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign req_fire             = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tpdo_number = rsp_num_ff;
   assign rsp_chan.cob_id      = rsp_cob_ff;
   assign rsp_chan.dlc         = rsp_dlc_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // current pdo fields
   assign pidx          = pdo_ff[IDX_W-1:0];
   assign cur_type      = trans_types_ff[8*pdo_ff +: 8];
   assign cur_timer     = event_timers_ff[16*pdo_ff +: 16];
   assign cur_inhibit   = inhibit_times_ff[16*pdo_ff +: 16];
   assign cur_valid     = pdo_flags_ff[4'(pdo_ff)];
   assign cur_timer_sup = pdo_flags_ff[4'(pdo_ff) + 4'd4];
   assign cur_inh_sup   = pdo_flags_ff[4'(pdo_ff) + 4'd8];
   assign cur_pend      = sync_pending_ff[pidx];
   assign sel_hit       = (sel_ff == 3'(pdo_ff));

   // operand select of the shared subtractor
   assign rem_shift = {rem_ff, cnt_ff[bit_ff]};
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      case (state_ff)
         S_LOAD: begin
            alu_a = ts_ff;
            alu_b = last_send_ff[pidx];
         end
         S_CMP: begin
            alu_a = diff_ff;
            alu_b = 32'(thr_ff);
         end
         S_MOD: begin
            alu_a = 32'(rem_shift);
            alu_b = 32'(cur_type);
         end
         default: ;
      endcase
   end
   assign alu_res    = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_borrow = alu_res[32];

   // trigger decision for the current pdo
   always_comb begin
      want_send = 1'b0;
      want_pend = 1'b0;
      unique case (op_ff)
         pdots_pkg::OP_TICK: begin
            want_send = (cur_type >= pdots_pkg::TT_EVENT1) && cur_timer_sup &&
                        (cur_timer != 16'd0) && ge_ff;
         end
         pdots_pkg::OP_SYNC: begin
            if (cur_type == pdots_pkg::TT_ACYCLIC || cur_type == pdots_pkg::TT_RTR_SYNC) begin
               want_send = cur_pend;
            end else if (cur_type <= pdots_pkg::TT_SYNC_MAX) begin
               want_send = (cnt_ff != 8'd0) && (rem_ff == 8'd0);
            end
         end
         pdots_pkg::OP_FRAME: begin
            want_send = rtr_ff && (cur_type == pdots_pkg::TT_RTR_EVENT);
            want_pend = rtr_ff && (cur_type == pdots_pkg::TT_RTR_SYNC);
         end
         pdots_pkg::OP_APP: begin
            want_pend = sel_hit && (cur_type == pdots_pkg::TT_ACYCLIC);
            want_send = sel_hit && (cur_type >= pdots_pkg::TT_EVENT1) &&
                        (!cur_inh_sup || cur_inhibit == 16'd0 || ge_ff);
         end
         default: ;
      endcase
   end
   assign send_now = enable_ff && want_send && cur_valid;

   // lowest pending result
   always_comb begin
      emit_idx = '0;
      for (int k = NUM_TPDOS - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            emit_idx = IDX_W'(k);
         end
      end
      mask_clr           = mask_ff;
      mask_clr[emit_idx] = 1'b0;
   end
   assign emit_pdo = pdots_pkg::PDO_W'(emit_idx);
   assign emit_len = payload_lengths_ff[4*emit_pdo +: 4];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ts_in        = ts_ff;
      cnt_in       = cnt_ff;
      sel_in       = sel_ff;
      rtr_in       = rtr_ff;
      pdo_in       = pdo_ff;
      mask_in      = mask_ff;
      diff_in      = diff_ff;
      thr_in       = thr_ff;
      ge_in        = ge_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_cob_in   = rsp_cob_ff;
      rsp_dlc_in   = rsp_dlc_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = pdots_pkg::opcode_type'(req_chan.opcode);
               ts_in   = req_chan.event_time_us;
               cnt_in  = req_chan.sync_count;
               sel_in  = req_chan.tpdo_select;
               rtr_in  = req_chan.is_rtr;
               pdo_in  = '0;
               mask_in = '0;
               // a disabled block drops the request
               if (enable_ff) begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            diff_in = alu_res[31:0];
            if (op_ff == pdots_pkg::OP_TICK) begin
               thr_in = 26'(32'(cur_timer) * pdots_pkg::MS_TO_US);
            end else begin
               thr_in = 26'(32'(cur_inhibit) * pdots_pkg::INH_UNIT_US);
            end
            rem_in = '0;
            bit_in = 3'd7;
            if (op_ff == pdots_pkg::OP_SYNC && cur_type != pdots_pkg::TT_ACYCLIC &&
                cur_type <= pdots_pkg::TT_SYNC_MAX) begin
               state_in = S_MOD;
            end else if (op_ff == pdots_pkg::OP_TICK || op_ff == pdots_pkg::OP_APP) begin
               state_in = S_CMP;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_CMP: begin
            ge_in    = !alu_borrow;
            state_in = S_DECIDE;
         end
         S_MOD: begin
            // restoring remainder, one count bit per cycle
            rem_in = alu_borrow ? rem_shift[7:0] : alu_res[7:0];
            if (bit_ff == 3'd0) begin
               state_in = S_DECIDE;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         S_DECIDE: begin
            mask_in[pidx] = send_now;
            if (pdo_ff == LAST_PDO) begin
               state_in = S_EMIT;
            end else begin
               pdo_in   = pdo_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_EMIT: begin
            if (mask_ff == '0) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = emit_pdo;
               rsp_cob_in   = cob_ids_ff[11*emit_pdo +: 11] & pdots_pkg::COB_MASK;
               rsp_dlc_in   = (emit_len > pdots_pkg::DLC_MAX) ? pdots_pkg::DLC_MAX : emit_len;
               rsp_last_in  = (mask_clr == '0);
               mask_in      = mask_clr;
               if (mask_clr == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ts_ff       <= ts_in;
      cnt_ff      <= cnt_in;
      sel_ff      <= sel_in;
      rtr_ff      <= rtr_in;
      pdo_ff      <= pdo_in;
      mask_ff     <= mask_in;
      diff_ff     <= diff_in;
      thr_ff      <= thr_in;
      ge_ff       <= ge_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_cob_ff  <= rsp_cob_in;
      rsp_dlc_ff  <= rsp_dlc_in;
      rsp_last_ff <= rsp_last_in;
   end

   // per pdo pending flag and last send time
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_TPDOS; k++) begin
            sync_pending_ff[k] <= 1'b0;
            last_send_ff[k]    <= '0;
         end
      end else if (state_ff == S_DECIDE) begin
         if (send_now) begin
            sync_pending_ff[pidx] <= 1'b0;
            last_send_ff[pidx]    <= ts_ff;
         end else if (enable_ff && want_pend) begin
            sync_pending_ff[pidx] <= 1'b1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff          <= 1'b0;
         trans_types_ff     <= '0;
         event_timers_ff    <= '0;
         inhibit_times_ff   <= '0;
         pdo_flags_ff       <= '0;
         cob_ids_ff         <= '0;
         payload_lengths_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pdots_pkg::REG_BLOCK_ENABLE:    enable_ff          <= csr_wdata[0];
            pdots_pkg::REG_TRANS_TYPES:     trans_types_ff     <= csr_wdata[31:0];
            pdots_pkg::REG_EVENT_TIMERS:    event_timers_ff    <= csr_wdata;
            pdots_pkg::REG_INHIBIT_TIMES:   inhibit_times_ff   <= csr_wdata;
            pdots_pkg::REG_PDO_FLAGS:       pdo_flags_ff       <= csr_wdata[11:0];
            pdots_pkg::REG_COB_IDS:         cob_ids_ff         <= csr_wdata[43:0];
            pdots_pkg::REG_PAYLOAD_LENGTHS: payload_lengths_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

endmodule

// ----- src/pdots_checker.sv -----
// pdots_checker: port-level checks of the scheduler top level
// bound to pdo_transmit_trigger_scheduler_top through plain signal ports
module pdots_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_dlc
);

   // reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a pending response is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // an idle block stays ready until a request comes
   assert property (@(posedge clock) disable iff (reset)
                    req_ready && !req_valid |=> req_ready)
      else $error("ready dropped without a request");

   // the walk needs cycles before a first result
   assert property (@(posedge clock) disable iff (reset)
                    req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result shown right after request");

   // length is clamped
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> rsp_dlc <= 4'd8)
      else $error("dlc above eight");

endmodule

bind pdo_transmit_trigger_scheduler_top pdots_checker u_pdots_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_dlc   (rsp_chan.dlc)
);
